FILE: rtl/core/sirlc_pkg.sv
// Shared types and constants for the SIR lattice cell update block.
// Used by sir_lattice_cell_update; no dependencies.
package sirlc_pkg;

    localparam int GRID_DIM_DEFAULT = 256;

    localparam int ROW_W     = 8;
    localparam int CELL_W    = 2;
    localparam int RAND_W    = 16;
    localparam int THR_W     = 17;
    localparam int TALLY_W   = 17;
    localparam int CFG_IDX_W = 1;
    localparam int PAIR_W    = 3;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CELL_W-1:0] CELL_S = 2'd0;
    localparam logic [CELL_W-1:0] CELL_I = 2'd1;
    localparam logic [CELL_W-1:0] CELL_R = 2'd2;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_INFECT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER = 1'd1;

    localparam logic [PAIR_W-1:0] PAIR_CENTER = 3'd0;
    localparam logic [PAIR_W-1:0] PAIR_UP     = 3'd1;
    localparam logic [PAIR_W-1:0] PAIR_SIDE   = 3'd2;
    localparam logic [PAIR_W-1:0] PAIR_DOWN   = 3'd3;
    localparam logic [PAIR_W-1:0] PAIR_CORNER = 3'd4;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 17'h1FFFF;

    typedef enum logic [2:0] {
        CTRL_CLEAR,
        CTRL_IDLE,
        CTRL_READ,
        CTRL_LAST,
        CTRL_DONE
    } ctrl_state_t;

endpackage

FILE: rtl/core/sir_lattice_cell_update.sv
// Top level of the SIR lattice cell update block: cell memory, sequencer and tallies.
// Depends on sirlc_pkg and sirlc_ram.
// A load or an out-of-grid request goes from IDLE straight to DONE; an update inside the grid
// passes through READ and LAST first, and a border update reads only the center cell.
// One item at a time; the next item is accepted once the previous result is registered.
// An interior update reads nine cells through the two read ports of the cell memory.
// After reset a clearing pass writes every cell susceptible, during which no item is
// accepted; configuration writes are taken at all times.
module sir_lattice_cell_update
    import sirlc_pkg::*;
#(
    parameter int GRID_DIM = GRID_DIM_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // s_tdata: row, col, load_state, rand_infect, rand_recover, start_generation, zero pad
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type
    input  logic                   s_tuser,
    // m_tdata: new_state, count_susceptible, count_infected, count_recovered, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: border_error
    output logic                   m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [THR_W-1:0]       cfg_data
);

    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW_STEP = AW'(GRID_DIM);
    localparam logic [AW-1:0] ONE      = AW'(1);

    ctrl_state_t state_reg, state_next;

    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [PAIR_W-1:0]  pair_reg, pair_next;
    logic [PAIR_W-1:0]  last_pair_reg, last_pair_next;
    logic               proc_valid_reg;
    logic [PAIR_W-1:0]  proc_pair_reg;

    logic               req_reg, req_next;
    logic [CELL_W-1:0]  ld_reg, ld_next;
    logic [RAND_W-1:0]  ri_reg, ri_next;
    logic [RAND_W-1:0]  rr_reg, rr_next;
    logic               gen_reg, gen_next;
    logic               inside_reg, inside_next;
    logic               border_reg, border_next;
    logic [AW-1:0]      base_reg, base_next;
    logic               near_reg, near_next;
    logic [CELL_W-1:0]  cur_reg, cur_next;

    logic [THR_W-1:0]   infect_thr_reg;
    logic [THR_W-1:0]   recover_thr_reg;

    logic [TALLY_W-1:0] tally_s_reg, tally_s_next;
    logic [TALLY_W-1:0] tally_i_reg, tally_i_next;
    logic [TALLY_W-1:0] tally_r_reg, tally_r_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata_a, ram_rdata_b;

    logic               in_accept;
    logic               out_free;
    logic [ROW_W-1:0]   in_row, in_col;
    logic               in_inside, in_border;

    logic [CELL_W-1:0]  res_state;
    logic               res_err;
    logic               res_write;
    logic               res_count;
    logic [TALLY_W-1:0] base_s, base_i, base_r;

    sirlc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_row    = s_tdata[7:0];
    assign in_col    = s_tdata[15:8];
    assign in_inside = (32'(in_row) < GRID_DIM) && (32'(in_col) < GRID_DIM);
    assign in_border = (in_row == '0) || (in_col == '0) ||
                       (32'(in_row) == GRID_DIM - 1) || (32'(in_col) == GRID_DIM - 1);

    always_comb
    begin
        res_state = CELL_S;
        res_err   = 1'b0;
        res_write = 1'b0;
        res_count = 1'b0;
        if (req_reg == REQ_LOAD)
        begin
            if (inside_reg)
            begin
                res_state = (ld_reg > CELL_R) ? CELL_R : ld_reg;
                res_write = 1'b1;
            end
        end
        else if (!inside_reg)
        begin
            res_err = 1'b1;
        end
        else if (border_reg)
        begin
            res_err   = 1'b1;
            res_state = cur_reg;
        end
        else
        begin
            res_write = 1'b1;
            res_count = 1'b1;
            case (cur_reg)
                CELL_S:  res_state = (near_reg && ({1'b0, ri_reg} < infect_thr_reg))
                                     ? CELL_I : CELL_S;
                CELL_I:  res_state = ({1'b0, rr_reg} < recover_thr_reg) ? CELL_R : CELL_I;
                default: res_state = CELL_R;
            endcase
        end
    end

    always_comb
    begin
        base_s = gen_reg ? '0 : tally_s_reg;
        base_i = gen_reg ? '0 : tally_i_reg;
        base_r = gen_reg ? '0 : tally_r_reg;
        tally_s_next = base_s;
        tally_i_next = base_i;
        tally_r_next = base_r;
        if (res_count)
        begin
            if (res_state == CELL_S && base_s != TALLY_MAX)
            begin
                tally_s_next = base_s + TALLY_W'(1);
            end
            else if (res_state == CELL_I && base_i != TALLY_MAX)
            begin
                tally_i_next = base_i + TALLY_W'(1);
            end
            else if (res_state == CELL_R && base_r != TALLY_MAX)
            begin
                tally_r_next = base_r + TALLY_W'(1);
            end
        end
    end

    always_comb
    begin
        case (pair_reg)
            PAIR_CENTER:
            begin
                ram_raddr_a = base_reg;
                ram_raddr_b = border_reg ? base_reg : base_reg - ROW_STEP - ONE;
            end
            PAIR_UP:
            begin
                ram_raddr_a = base_reg - ROW_STEP;
                ram_raddr_b = base_reg - ROW_STEP + ONE;
            end
            PAIR_SIDE:
            begin
                ram_raddr_a = base_reg - ONE;
                ram_raddr_b = base_reg + ONE;
            end
            PAIR_DOWN:
            begin
                ram_raddr_a = base_reg + ROW_STEP - ONE;
                ram_raddr_b = base_reg + ROW_STEP;
            end
            default:
            begin
                ram_raddr_a = base_reg + ROW_STEP + ONE;
                ram_raddr_b = base_reg + ROW_STEP + ONE;
            end
        endcase
    end

    always_comb
    begin
        near_next = near_reg;
        cur_next  = cur_reg;
        if (proc_valid_reg)
        begin
            if (proc_pair_reg == PAIR_CENTER)
            begin
                cur_next  = ram_rdata_a;
                near_next = near_reg || (!border_reg && ram_rdata_b == CELL_I);
            end
            else
            begin
                near_next = near_reg || (ram_rdata_a == CELL_I) || (ram_rdata_b == CELL_I);
            end
        end
        if (in_accept)
        begin
            near_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        pair_next      = pair_reg;
        last_pair_next = last_pair_reg;
        s_tready       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = base_reg;
        ram_wdata      = res_state;
        ram_re         = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        req_next       = req_reg;
        ld_next        = ld_reg;
        ri_next        = ri_reg;
        rr_next        = rr_reg;
        gen_next       = gen_reg;
        inside_next    = inside_reg;
        border_next    = border_reg;
        base_next      = base_reg;
        case (state_reg)
            CTRL_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = CELL_S;
                clr_addr_next = clr_addr_reg + ONE;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = CTRL_IDLE;
                end
            end
            CTRL_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    req_next       = s_tuser;
                    ld_next        = s_tdata[17:16];
                    ri_next        = s_tdata[33:18];
                    rr_next        = s_tdata[49:34];
                    gen_next       = s_tdata[50];
                    inside_next    = in_inside;
                    border_next    = in_border;
                    base_next      = AW'(32'(in_row) * GRID_DIM + 32'(in_col));
                    pair_next      = PAIR_CENTER;
                    last_pair_next = in_border ? PAIR_CENTER : PAIR_CORNER;
                    if (s_tuser == REQ_UPDATE && in_inside)
                    begin
                        state_next = CTRL_READ;
                    end
                    else
                    begin
                        state_next = CTRL_DONE;
                    end
                end
            end
            CTRL_READ:
            begin
                ram_re = 1'b1;
                if (pair_reg == last_pair_reg)
                begin
                    state_next = CTRL_LAST;
                end
                else
                begin
                    pair_next = pair_reg + PAIR_W'(1);
                end
            end
            CTRL_LAST:
            begin
                state_next = CTRL_DONE;
            end
            CTRL_DONE:
            begin
                if (out_free)
                begin
                    ram_we        = res_write;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, tally_r_next, tally_i_next, tally_s_next,
                                     res_state};
                    m_tuser_next  = res_err;
                    state_next    = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg    <= '0;
            pair_reg        <= PAIR_CENTER;
            last_pair_reg   <= PAIR_CENTER;
            proc_valid_reg  <= 1'b0;
            proc_pair_reg   <= PAIR_CENTER;
            m_tvalid_reg    <= 1'b0;
            infect_thr_reg  <= '0;
            recover_thr_reg <= '0;
            tally_s_reg     <= '0;
            tally_i_reg     <= '0;
            tally_r_reg     <= '0;
        end
        else
        begin
            clr_addr_reg   <= clr_addr_next;
            pair_reg       <= pair_next;
            last_pair_reg  <= last_pair_next;
            proc_valid_reg <= ram_re;
            proc_pair_reg  <= pair_reg;
            m_tvalid_reg   <= m_tvalid_next;
            if (state_reg == CTRL_DONE && out_free)
            begin
                tally_s_reg <= tally_s_next;
                tally_i_reg <= tally_i_next;
                tally_r_reg <= tally_r_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INFECT:  infect_thr_reg  <= cfg_data;
                    REG_RECOVER: recover_thr_reg <= cfg_data;
                    default:     infect_thr_reg  <= infect_thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        ld_reg      <= ld_next;
        ri_reg      <= ri_next;
        rr_reg      <= rr_next;
        gen_reg     <= gen_next;
        inside_reg  <= inside_next;
        border_reg  <= border_next;
        base_reg    <= base_next;
        near_reg    <= near_next;
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Reads and writes of the cell memory never share a cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("cell memory read and write in the same cycle");

    // Read pairs never run past the last neighbor pair.
    assert property (@(posedge clk) disable iff (!rst_n) ram_re |-> (pair_reg <= PAIR_CORNER))
        else $error("read pair index out of range");

    // A new result only appears after the finishing step of an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == CTRL_DONE))
        else $error("result raised outside the finishing step");

    // No result is produced while the memory is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CTRL_CLEAR) |-> (!m_tvalid_reg && !s_tready))
        else $error("activity during the clearing pass");

endmodule

FILE: rtl/core/sirlc_ram.sv
// Generic RAM with one write port and two registered read ports.
// Standalone; no package dependencies.
module sirlc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
